[rtl/toggle_kicked_watchdog_controller_macros.svh]
// Assertion macros for the toggle-kicked watchdog controller.
// They use the clk and rst_n names of the module that includes this file.
`ifndef TOGGLE_KICKED_WATCHDOG_CONTROLLER_MACROS_SVH
`define TOGGLE_KICKED_WATCHDOG_CONTROLLER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TKWD_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define TKWD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TKWD_ASSERT_ALWAYS(lbl, expr, msg)
`define TKWD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/tkwd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkwd_pkg
// Shared codes, defaults and types of the toggle-kicked watchdog controller.
// ----------------------------------------------------------------------------
package tkwd_pkg;

    localparam int TIMER_BITS_DEF = 24;
    localparam int CFG_BITS       = 24;

    localparam logic [2:0] ST_STARTUP = 3'd0;
    localparam logic [2:0] ST_TRIGDLY = 3'd1;
    localparam logic [2:0] ST_IDLE    = 3'd2;
    localparam logic [2:0] ST_MON     = 3'd3;
    localparam logic [2:0] ST_WARN    = 3'd4;

    localparam logic [2:0] LT_GREEN  = 3'b001;
    localparam logic [2:0] LT_YELLOW = 3'b010;
    localparam logic [2:0] LT_RED    = 3'b100;

    localparam logic [3:0] COUNT_MAX = 4'd10;

    localparam logic [2:0] REG_WATCHDOG_MODE = 3'd0;
    localparam logic [2:0] REG_TIMEOUT       = 3'd1;
    localparam logic [2:0] REG_WARNING       = 3'd2;
    localparam logic [2:0] REG_TRIG_DELAY    = 3'd3;
    localparam logic [2:0] REG_START_DELAY   = 3'd4;
    localparam logic [2:0] REG_THRESHOLD     = 3'd5;
    localparam logic [2:0] REG_WRITE_ON_START = 3'd6;

    typedef struct packed {
        logic                watchdog_mode;
        logic [CFG_BITS-1:0] timeout_ticks;
        logic [CFG_BITS-1:0] warning_ticks;
        logic [CFG_BITS-1:0] trigger_delay_ticks;
        logic [CFG_BITS-1:0] startup_delay_ticks;
        logic [3:0]          toggle_threshold;
        logic                write_on_start;
    } cfg_t;

    typedef struct packed {
        logic [2:0] machine_state;
        logic [2:0] lights;
        logic       write_text;
    } result_t;

endpackage

`default_nettype wire

[rtl/tkwd_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkwd_step
// One rule step: applies a tick or a byte report, then runs the state rules.
// ----------------------------------------------------------------------------
module tkwd_step
    import tkwd_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  cfg_t                  cfg,
    input  logic                  mode,
    input  logic [7:0]            led_byte,
    input  logic                  started,
    input  logic [2:0]            cur_state,
    input  logic [TIMER_BITS-1:0] timer,
    input  logic [3:0]            count,
    input  logic [7:0]            last_byte,
    input  logic [TIMER_BITS-1:0] delay_begin,
    input  logic                  delay_running,
    output logic [2:0]            state_next,
    output logic [TIMER_BITS-1:0] timer_next,
    output logic [3:0]            count_next,
    output logic [7:0]            last_byte_next,
    output logic [TIMER_BITS-1:0] delay_begin_next,
    output logic                  delay_running_next,
    output result_t               result
);

    localparam int CW = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

    logic [2:0]            home;
    logic [2:0]            s0;
    logic [2:0]            s;
    logic [TIMER_BITS-1:0] tmr;
    logic [3:0]            cnt;
    logic                  trig;
    logic                  fire;
    logic [TIMER_BITS-1:0] beg_eff;
    logic [TIMER_BITS-1:0] elapsed;
    logic [CW-1:0]         elapsed_w;
    logic [CW-1:0]         tmr_w;
    logic                  not_before;

    always_comb
    begin
        home = cfg.watchdog_mode ? ST_MON : ST_IDLE;
        s0   = started ? cur_state : (cfg.write_on_start ? ST_STARTUP : home);

        tmr            = timer;
        cnt            = count;
        last_byte_next = last_byte;
        if (!mode)
        begin
            if (timer != {TIMER_BITS{1'b1}})
                tmr = timer + 1'b1;
        end
        else
        begin
            if (led_byte != last_byte && count < COUNT_MAX)
                cnt = count + 4'd1;
            last_byte_next = led_byte;
        end

        trig  = cnt > cfg.toggle_threshold;
        tmr_w = CW'(tmr);

        // delay starts now if not yet running
        beg_eff    = delay_running ? delay_begin : tmr;
        not_before = tmr >= beg_eff;
        elapsed    = tmr - beg_eff;
        elapsed_w  = CW'(elapsed);

        s                  = s0;
        fire               = 1'b0;
        delay_begin_next   = delay_begin;
        delay_running_next = delay_running;

        unique case (s0)
            ST_STARTUP:
            begin
                delay_begin_next   = beg_eff;
                delay_running_next = 1'b1;
                if (not_before && elapsed_w >= CW'(cfg.startup_delay_ticks))
                    fire = 1'b1;
            end
            ST_TRIGDLY:
            begin
                delay_begin_next   = beg_eff;
                delay_running_next = 1'b1;
                if (not_before && elapsed_w >= CW'(cfg.trigger_delay_ticks))
                    fire = 1'b1;
            end
            ST_MON:
            begin
                if (trig)
                begin
                    tmr   = '0;
                    cnt   = '0;
                    tmr_w = '0;
                end
                if (tmr_w > CW'(cfg.warning_ticks))
                    s = ST_WARN;
            end
            ST_WARN:
            begin
                if (trig)
                begin
                    s     = ST_MON;
                    tmr   = '0;
                    cnt   = '0;
                    tmr_w = '0;
                end
                if (tmr_w > CW'(cfg.timeout_ticks))
                    fire = 1'b1;
            end
            default:
            begin
                if (trig)
                begin
                    s                  = ST_TRIGDLY;
                    delay_begin_next   = tmr;
                    delay_running_next = 1'b1;
                end
                else
                begin
                    s = ST_IDLE;
                end
            end
        endcase

        if (fire)
        begin
            tmr                = '0;
            cnt                = '0;
            delay_running_next = 1'b0;
            s                  = home;
        end

        state_next           = s;
        timer_next           = tmr;
        count_next           = cnt;
        result.machine_state = s;
        result.write_text    = fire;
        if (fire)
            result.lights = LT_RED;
        else if (s == ST_STARTUP || s == ST_TRIGDLY)
            result.lights = LT_YELLOW;
        else if (s == ST_WARN)
            result.lights = LT_GREEN | LT_YELLOW;
        else
            result.lights = LT_GREEN;
    end

endmodule

`default_nettype wire

[rtl/toggle_kicked_watchdog_controller.sv]
// A result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle unless a held result stalls s_axis_tready; the single rule step between the
// state registers and the result register sets this figure.
// Reset (rst_n low, asynchronous): state machine unstarted, timer, count,
// last byte and delay cleared, configuration at its defaults.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// toggle_kicked_watchdog_controller
// Watchdog kicked by indicator-byte toggles, with startup and trigger delays.
// ----------------------------------------------------------------------------
`include "toggle_kicked_watchdog_controller_macros.svh"

module toggle_kicked_watchdog_controller
    import tkwd_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] led_byte
    input  logic                s_axis_tuser,   // [0] mode
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // [2:0] machine_state, [5:3] lights,
                                                // [6] write_text, [7] zero
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data
);

    cfg_t                  cfg_reg;
    logic                  started_reg;
    logic [2:0]            state_reg;
    logic [TIMER_BITS-1:0] timer_reg;
    logic [3:0]            count_reg;
    logic [7:0]            last_byte_reg;
    logic [TIMER_BITS-1:0] begin_reg;
    logic                  running_reg;
    logic                  out_valid_reg;
    result_t               out_reg;

    logic [2:0]            state_next;
    logic [TIMER_BITS-1:0] timer_next;
    logic [3:0]            count_next;
    logic [7:0]            last_byte_next;
    logic [TIMER_BITS-1:0] begin_next;
    logic                  running_next;
    result_t               step_result;
    logic                  accept;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg.write_text, out_reg.lights, out_reg.machine_state};

    tkwd_step #(
        .TIMER_BITS(TIMER_BITS)
    ) u_step (
        .cfg                (cfg_reg),
        .mode               (s_axis_tuser),
        .led_byte           (s_axis_tdata),
        .started            (started_reg),
        .cur_state          (state_reg),
        .timer              (timer_reg),
        .count              (count_reg),
        .last_byte          (last_byte_reg),
        .delay_begin        (begin_reg),
        .delay_running      (running_reg),
        .state_next         (state_next),
        .timer_next         (timer_next),
        .count_next         (count_next),
        .last_byte_next     (last_byte_next),
        .delay_begin_next   (begin_next),
        .delay_running_next (running_next),
        .result             (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.watchdog_mode       <= 1'b0;
            cfg_reg.timeout_ticks       <= CFG_BITS'(3000);
            cfg_reg.warning_ticks       <= CFG_BITS'(2400);
            cfg_reg.trigger_delay_ticks <= CFG_BITS'(600);
            cfg_reg.startup_delay_ticks <= CFG_BITS'(300);
            cfg_reg.toggle_threshold    <= 4'd3;
            cfg_reg.write_on_start      <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WATCHDOG_MODE:  cfg_reg.watchdog_mode       <= cfg_data[0];
                REG_TIMEOUT:        cfg_reg.timeout_ticks       <= cfg_data;
                REG_WARNING:        cfg_reg.warning_ticks       <= cfg_data;
                REG_TRIG_DELAY:     cfg_reg.trigger_delay_ticks <= cfg_data;
                REG_START_DELAY:    cfg_reg.startup_delay_ticks <= cfg_data;
                REG_THRESHOLD:      cfg_reg.toggle_threshold    <= cfg_data[3:0];
                REG_WRITE_ON_START: cfg_reg.write_on_start      <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            state_reg     <= ST_STARTUP;
            timer_reg     <= '0;
            count_reg     <= '0;
            last_byte_reg <= '0;
            begin_reg     <= '0;
            running_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                started_reg   <= 1'b1;
                state_reg     <= state_next;
                timer_reg     <= timer_next;
                count_reg     <= count_next;
                last_byte_reg <= last_byte_next;
                begin_reg     <= begin_next;
                running_reg   <= running_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= step_result;
    end

    `TKWD_ASSERT_ALWAYS(a_count_sat, count_reg <= COUNT_MAX, "toggle count above saturation")
    `TKWD_ASSERT_ALWAYS(a_state_legal, !started_reg || state_reg <= ST_WARN, "illegal state code")
    `TKWD_ASSERT_NEXT(a_fire_clears, accept && step_result.write_text, timer_reg == '0 && count_reg == '0 && !running_reg, "write did not clear timer and count")
    `TKWD_ASSERT_NEXT(a_result_follows, accept, out_valid_reg && out_reg.machine_state == state_reg, "result does not match new state")

endmodule

`default_nettype wire

[tb/toggle_kicked_watchdog_controller_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toggle_kicked_watchdog_controller_tb
// Self-checking bench: directed startup, trigger-delay and watchdog-kick
// sequences, then register sweeps with segmented random tick/report traffic,
// bursty input, patterned output stalls and one long output hold-off. Every
// result is compared field by field against an in-bench step predictor.
// ----------------------------------------------------------------------------
module toggle_kicked_watchdog_controller_tb;
    import tkwd_pkg::*;

    localparam int LIMIT_CYCLES     = 400000;
    localparam int RESET_CYCLES     = 6;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int PHASES           = 11;
    localparam int PHASE_ITEMS      = 110;
    localparam int MAX_PRINTS       = 30;

    localparam logic [CFG_BITS-1:0] TICKS_MAX = '1;
    localparam logic [TIMER_BITS_DEF-1:0] TIMER_TOP = '1;

    localparam logic EV_TICK   = 1'b0;
    localparam logic EV_REPORT = 1'b1;

    typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_EVERY_THIRD} rx_pattern_t;

    logic                clk;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata  = 8'h00;  // [7:0] led_byte
    logic                s_axis_tuser  = 1'b0;   // [0] mode
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [7:0]          m_axis_tdata;           // [2:0] state, [5:3] lights, [6] write
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    logic [2:0]          cfg_index     = REG_WATCHDOG_MODE;
    logic [CFG_BITS-1:0] cfg_data      = '0;

    // predictor state
    cfg_t                      shadow_cfg;
    logic                      wd_started;
    logic [2:0]                wd_state;
    logic [TIMER_BITS_DEF-1:0] wd_timer;
    logic [TIMER_BITS_DEF-1:0] wd_delay_begin;
    logic                      wd_delay_running;
    logic [3:0]                wd_toggles;
    logic [7:0]                wd_last_byte;
    result_t                   step_outcomes_due[$];

    int   cycle_count    = 0;
    int   mismatches     = 0;
    int   requests_sent  = 0;
    int   results_seen   = 0;
    int   write_pulses   = 0;
    int   config_writes  = 0;
    int   burst_left     = 0;
    logic sender_bursty  = 1'b1;
    logic long_hold_req  = 1'b0;
    logic [7:0] last_sent_byte = 8'h00;
    logic [7:0] states_seen    = 8'h00;

    toggle_kicked_watchdog_controller #(
        .TIMER_BITS (TIMER_BITS_DEF)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES)
            begin
                $display("Timeout after %0d cycles, %0d results pending",
                         cycle_count, step_outcomes_due.size());
                $display("toggle_kicked_watchdog_controller test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Step predictor
    // ------------------------------------------------------------------
    function automatic logic [2:0] home_state();
        return shadow_cfg.watchdog_mode ? ST_MON : ST_IDLE;
    endfunction

    function automatic logic delay_elapsed(input logic [CFG_BITS-1:0] len);
        if (wd_timer < wd_delay_begin)
            return 1'b0;
        return (wd_timer - wd_delay_begin) >= len;
    endfunction

    function automatic logic [2:0] lights_for(input logic [2:0] st);
        case (st)
            ST_STARTUP, ST_TRIGDLY: return LT_YELLOW;
            ST_WARN:                return LT_GREEN | LT_YELLOW;
            default:                return LT_GREEN;
        endcase
    endfunction

    function automatic result_t predict_watchdog_step(input logic ev, input logic [7:0] b);
        logic [2:0] st;
        logic       fire;
        logic       kick;
        result_t    r;
        fire = 1'b0;
        if (!wd_started)
        begin
            wd_started = 1'b1;
            wd_state   = shadow_cfg.write_on_start ? ST_STARTUP : home_state();
        end
        if (ev == EV_TICK)
        begin
            if (wd_timer != TIMER_TOP)
                wd_timer = wd_timer + 1'b1;
        end
        else
        begin
            if (b != wd_last_byte && wd_toggles < COUNT_MAX)
                wd_toggles = wd_toggles + 1'b1;
            wd_last_byte = b;
        end
        st   = wd_state;
        kick = wd_toggles > shadow_cfg.toggle_threshold;
        case (st)
            ST_STARTUP, ST_TRIGDLY:
            begin
                if (!wd_delay_running)
                begin
                    wd_delay_begin   = wd_timer;
                    wd_delay_running = 1'b1;
                end
                fire = delay_elapsed(st == ST_STARTUP ? shadow_cfg.startup_delay_ticks
                                                      : shadow_cfg.trigger_delay_ticks);
            end
            ST_MON:
            begin
                if (kick)
                begin
                    wd_timer   = '0;
                    wd_toggles = '0;
                end
                if (wd_timer > shadow_cfg.warning_ticks)
                    st = ST_WARN;
            end
            ST_WARN:
            begin
                if (kick)
                begin
                    st         = ST_MON;
                    wd_timer   = '0;
                    wd_toggles = '0;
                end
                if (wd_timer > shadow_cfg.timeout_ticks)
                    fire = 1'b1;
            end
            default:
            begin
                if (kick)
                begin
                    st               = ST_TRIGDLY;
                    wd_delay_begin   = wd_timer;
                    wd_delay_running = 1'b1;
                end
                else
                    st = ST_IDLE;
            end
        endcase
        if (fire)
        begin
            wd_timer         = '0;
            wd_toggles       = '0;
            wd_delay_running = 1'b0;
            st               = home_state();
        end
        wd_state        = st;
        r.machine_state = st;
        r.lights        = fire ? LT_RED : lights_for(st);
        r.write_text    = fire;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("MISMATCH %s: expected %0h, got %0h (result %0d, cycle %0d)",
                     what, want, got, results_seen, cycle_count);
    endtask

    task automatic check_outcome(input logic [7:0] got);
        result_t want;
        if (step_outcomes_due.size() == 0)
            report_mismatch("result with no request pending", 0, got);
        else
        begin
            want = step_outcomes_due.pop_front();
            if (got[2:0] !== want.machine_state)
                report_mismatch("machine_state", want.machine_state, got[2:0]);
            if (got[5:3] !== want.lights)
                report_mismatch("lights", want.lights, got[5:3]);
            if (got[6] !== want.write_text)
                report_mismatch("write_text", want.write_text, got[6]);
            if (got[7] !== 1'b0)
                report_mismatch("pad bit", 0, got[7]);
            if (want.write_text)
                write_pulses++;
            states_seen[want.machine_state] = 1'b1;
            results_seen++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_outcome(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                step_outcomes_due.push_back(predict_watchdog_step(s_axis_tuser, s_axis_tdata));
        end
    end

    // ------------------------------------------------------------------
    // Output stalls
    // ------------------------------------------------------------------
    initial
    begin
        rx_pattern_t pattern;
        int          left;
        int          k;
        pattern = RX_OPEN;
        left    = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                m_axis_tready <= 1'b0;
                for (k = 1; k < LONG_HOLD_CYCLES; k++)
                    @(negedge clk);
                long_hold_req = 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    pattern = rx_pattern_t'($urandom_range(0, 3));
                    left    = $urandom_range(16, 200);
                end
                left--;
                case (pattern)
                    RX_OPEN:   m_axis_tready <= 1'b1;
                    RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_axis_tready <= (left % 3 == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_request(input logic ev, input logic [7:0] b);
        int gap;
        if (sender_bursty && burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= ev;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        requests_sent++;
        if (ev == EV_REPORT)
            last_sent_byte = b;
    endtask

    task automatic send_random_request();
        logic       ev;
        logic [7:0] b;
        ev = 1'($urandom_range(0, 1));
        b  = ($urandom_range(0, 3) == 0) ? last_sent_byte : 8'($urandom);
        send_request(ev, b);
    endtask

    task automatic wait_all_outcomes();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (step_outcomes_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [CFG_BITS-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_WATCHDOG_MODE:  shadow_cfg.watchdog_mode       = val[0];
            REG_TIMEOUT:        shadow_cfg.timeout_ticks       = val;
            REG_WARNING:        shadow_cfg.warning_ticks       = val;
            REG_TRIG_DELAY:     shadow_cfg.trigger_delay_ticks = val;
            REG_START_DELAY:    shadow_cfg.startup_delay_ticks = val;
            REG_THRESHOLD:      shadow_cfg.toggle_threshold    = val[3:0];
            REG_WRITE_ON_START: shadow_cfg.write_on_start      = val[0];
            default:            ;
        endcase
        config_writes++;
    endtask

    task automatic apply_settings(input logic wd, input logic [CFG_BITS-1:0] tmo,
                                  input logic [CFG_BITS-1:0] wrn,
                                  input logic [CFG_BITS-1:0] tdl,
                                  input logic [CFG_BITS-1:0] sdl,
                                  input logic [3:0] thr, input logic wos);
        write_reg(REG_WATCHDOG_MODE, CFG_BITS'(wd));
        write_reg(REG_TIMEOUT, tmo);
        write_reg(REG_WARNING, wrn);
        write_reg(REG_TRIG_DELAY, tdl);
        write_reg(REG_START_DELAY, sdl);
        write_reg(REG_THRESHOLD, CFG_BITS'(thr));
        write_reg(REG_WRITE_ON_START, CFG_BITS'(wos));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // startup delay of three ticks, byte report mid-delay, write into idle
    task automatic test_startup();
        apply_settings(1'b0, 24'd3000, 24'd2400, 24'd2, 24'd3, 4'd3, 1'b1);
        send_request(EV_TICK, 8'h00);
        send_request(EV_REPORT, 8'hFF);
        repeat (3) send_request(EV_TICK, 8'hFF);
    endtask

    // toggles past the threshold, repeated byte, trigger delay expiry
    task automatic test_trigger_delay();
        send_request(EV_REPORT, 8'h00);
        send_request(EV_REPORT, 8'hFF);
        send_request(EV_REPORT, 8'hFF);
        send_request(EV_REPORT, 8'hAA);
        send_request(EV_REPORT, 8'h55);
        send_request(EV_TICK, 8'h00);
        send_request(EV_TICK, 8'hFF);
    endtask

    // watchdog mode: monitoring, warning, kick back, timeout write
    task automatic test_watchdog_kick();
        wait_all_outcomes();
        apply_settings(1'b1, 24'd4, 24'd2, 24'd1, TICKS_MAX, 4'd0, 1'b0);
        send_request(EV_REPORT, 8'h01);
        send_request(EV_TICK, 8'h00);
        repeat (3) send_request(EV_TICK, 8'h00);
        send_request(EV_REPORT, 8'h01);
        send_request(EV_REPORT, 8'hFE);
        repeat (5) send_request(EV_TICK, 8'h00);
    endtask

    // output held off long enough that the input side must stall
    task automatic test_backpressure();
        wait_all_outcomes();
        sender_bursty = 1'b0;
        long_hold_req = 1'b1;
        repeat (40) send_random_request();
        wait (!long_hold_req);
        sender_bursty = 1'b1;
        wait_all_outcomes();
    endtask

    task automatic run_random_phase(input int phase);
        logic [CFG_BITS-1:0] tmo;
        logic [CFG_BITS-1:0] wrn;
        logic [CFG_BITS-1:0] tdl;
        logic [CFG_BITS-1:0] sdl;
        logic [3:0]          thr;
        logic                wd;
        int                  sent;
        int                  len;
        int                  kind;
        int                  k;
        logic [7:0]          b;
        wait_all_outcomes();
        case (phase % 4)
            0:
            begin
                tmo = '0;
                wrn = '0;
                tdl = '0;
                sdl = '0;
            end
            1:
            begin
                tmo = TICKS_MAX;
                wrn = TICKS_MAX;
                tdl = TICKS_MAX;
                sdl = TICKS_MAX;
            end
            default:
            begin
                tmo = CFG_BITS'($urandom_range(0, 30));
                wrn = CFG_BITS'($urandom_range(0, 20));
                tdl = CFG_BITS'($urandom_range(0, 25));
                sdl = CFG_BITS'($urandom);
            end
        endcase
        case (phase % 5)
            0:       thr = 4'd0;
            1:       thr = 4'd9;
            2:       thr = 4'd15;
            default: thr = 4'($urandom_range(0, 9));
        endcase
        wd = 1'(((phase >> 2) ^ phase) & 1);
        apply_settings(wd, tmo, wrn, tdl, sdl, thr, 1'($urandom_range(0, 1)));
        sender_bursty = (phase % 3 != 2);
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 4)
                len = $urandom_range(1, 40);
            else if (kind < 7)
                len = $urandom_range(1, 12);
            else
                len = $urandom_range(1, 10);
            for (k = 0; k < len && sent < PHASE_ITEMS; k++)
            begin
                if (kind < 4)
                    send_request(EV_TICK, 8'($urandom));
                else if (kind < 7)
                begin
                    // mostly real toggles to reach kicks and triggers
                    b = $urandom_range(0, 1) ? last_sent_byte ^ (8'h01 << $urandom_range(0, 7))
                                             : 8'($urandom);
                    send_request(EV_REPORT, b);
                end
                else
                    send_random_request();
                sent++;
            end
        end
    endtask

    task automatic test_random_phases();
        int p;
        for (p = 0; p < PHASES; p++)
            run_random_phase(p);
        sender_bursty = 1'b1;
    endtask

    initial
    begin
        shadow_cfg.watchdog_mode       = 1'b0;
        shadow_cfg.timeout_ticks       = 24'd3000;
        shadow_cfg.warning_ticks       = 24'd2400;
        shadow_cfg.trigger_delay_ticks = 24'd600;
        shadow_cfg.startup_delay_ticks = 24'd300;
        shadow_cfg.toggle_threshold    = 4'd3;
        shadow_cfg.write_on_start      = 1'b1;
        wd_started       = 1'b0;
        wd_state         = ST_STARTUP;
        wd_timer         = '0;
        wd_delay_begin   = '0;
        wd_delay_running = 1'b0;
        wd_toggles       = '0;
        wd_last_byte     = 8'h00;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_startup();
        test_trigger_delay();
        test_watchdog_kick();
        test_backpressure();
        test_random_phases();

        wait_all_outcomes();
        repeat (5) @(posedge clk);

        $display("Ran %0d requests, checked %0d results with %0d write pulses",
                 requests_sent, results_seen, write_pulses);
        $display("Made %0d register writes; state codes reached (bit per code): %05b",
                 config_writes, states_seen[4:0]);
        if (mismatches == 0 && step_outcomes_due.size() == 0)
            $display("toggle_kicked_watchdog_controller test passed");
        else
            $display("toggle_kicked_watchdog_controller test failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/tkwd_pkg.sv
rtl/tkwd_step.sv
rtl/toggle_kicked_watchdog_controller.sv
tb/toggle_kicked_watchdog_controller_tb.sv
